FILE: rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and codes of the peer connection table
// Holds the stored entry layout, the request and result records and the
// request and status codes used by the table store and its sequencer.
// ----------------------------------------------------------------------------
package pct_pkg;

	// Request codes; any other code is served as a lookup.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_NEW     = 2'd0;
	localparam logic [1:0] ST_FOUND   = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	// Value of the slot count register after reset.
	localparam logic [4:0] SLOTS_RESET = 5'd16;

	typedef struct packed {
		logic active;
		logic server;
		logic connected;
	} pct_flags_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [15:0] portnum;
		logic [7:0]  ident;
		pct_flags_t  flags;
		logic [31:0] stamp;
	} pct_entry_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key_ip;
		logic [15:0] key_port;
		logic [7:0]  peer_id;
		logic        connected_in;
		logic        server_in;
		logic        active_in;
		logic [31:0] stamp_in;
	} pct_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot;
		logic [7:0]  out_id;
		logic        out_connected;
		logic        out_server;
		logic        out_active;
		logic [31:0] out_stamp;
		logic        table_full;
	} pct_rsp_t;

	typedef struct packed {
		logic       en;
		pct_entry_t data;
	} pct_wr_t;

endpackage

FILE: rtl/pct_if.sv
// ----------------------------------------------------------------------------
// pct_if: channel interfaces of the peer connection table
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Request channel.
interface pct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] key_ip;
	logic [15:0] key_port;
	logic [7:0]  peer_id;
	logic        connected_in;
	logic        server_in;
	logic        active_in;
	logic [31:0] stamp_in;

	modport source (output valid, req_type, key_ip, key_port, peer_id, connected_in,
		server_in, active_in, stamp_in, input ready);
	modport sink (input valid, req_type, key_ip, key_port, peer_id, connected_in,
		server_in, active_in, stamp_in, output ready);
endinterface

// Result channel.
interface pct_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic [7:0]  out_id;
	logic        out_connected;
	logic        out_server;
	logic        out_active;
	logic [31:0] out_stamp;
	logic        table_full;

	modport source (output valid, status, slot, out_id, out_connected, out_server,
		out_active, out_stamp, table_full, input ready);
	modport sink (input valid, status, slot, out_id, out_connected, out_server,
		out_active, out_stamp, table_full, output ready);
endinterface

// Configuration write channel for the slot count register.
interface pct_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/pct_store.sv
// ----------------------------------------------------------------------------
// pct_store: entry memory of the peer connection table
// One write port and one registered read port. A valid bit per slot makes a
// slot that was never written read as an all-zero entry after reset.
// ----------------------------------------------------------------------------
module pct_store #(
	parameter int MAX_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IDX_W-1:0]    rd_addr,
	output pct_pkg::pct_entry_t rd_data,
	input  logic [IDX_W-1:0]    wr_addr,
	input  pct_pkg::pct_wr_t    wr
);

	pct_pkg::pct_entry_t    mem_q [MAX_SLOTS];
	pct_pkg::pct_entry_t    rd_mem_q;
	logic [MAX_SLOTS-1:0]   vld_q;
	logic                   rd_vld_q;

	// Entry memory: written and read in the clock domain, no reset.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_mem_q <= mem_q[rd_addr];
		end
	end

	// Valid bits, cleared at once by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// A slot never written reads as the cleared entry.
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

FILE: rtl/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl: request sequencer of the peer connection table
// Scans the used slots one per cycle through a single key comparator, notes
// the first match, the first inactive slot and the count of inactive slots,
// then writes back at most one entry and builds the result.
// ----------------------------------------------------------------------------
module pct_ctrl #(
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	pct_req_if.sink             req,
	pct_rsp_if.source           rsp,
	input  logic [CNT_W-1:0]    n_used,
	output logic                rd_en,
	output logic [IDX_W-1:0]    rd_addr,
	input  pct_pkg::pct_entry_t rd_data,
	output logic [IDX_W-1:0]    wr_addr,
	output pct_pkg::pct_wr_t    wr
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t              state_q;
	pct_pkg::pct_req_t   req_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    issue_q;
	logic [CNT_W-1:0]    issue_nxt;
	logic                rvld_s1;
	logic                last_s1;
	logic [IDX_W-1:0]    ridx_s1;
	logic                have_match_q;
	logic [IDX_W-1:0]    match_idx_q;
	pct_pkg::pct_entry_t match_ent_q;
	logic                have_free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [31:0]         free_stamp_q;
	logic [CNT_W-1:0]    inact_q;
	pct_pkg::pct_rsp_t   res_q;
	pct_pkg::pct_rsp_t   rsp_q;
	logic                rsp_valid_q;

	logic                req_xfer;
	logic                key_hit;
	logic                is_add;
	logic                is_update;
	logic                do_new;
	logic                do_upd;
	logic [IDX_W-1:0]    sel_idx;
	logic [3:0]          slot_low;
	logic [CNT_W-1:0]    inact_left;
	pct_pkg::pct_entry_t wr_ent;
	pct_pkg::pct_rsp_t   res_d;
	logic                rsp_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	// Read issue during the scan; one slot a cycle.
	assign rd_en     = (state_q == ST_SCAN) && (issue_q != n_q);
	assign rd_addr   = issue_q[IDX_W-1:0];
	assign issue_nxt = issue_q + 1'b1;

	// The shared key comparator works on the returned entry.
	assign key_hit = (rd_data.addr == req_q.key_ip) && (rd_data.portnum == req_q.key_port);

	// Write-back decision once the scan is complete.
	assign is_add    = (req_q.req_type == pct_pkg::REQ_ADD);
	assign is_update = (req_q.req_type == pct_pkg::REQ_UPDATE);
	assign do_upd    = is_update && have_match_q;
	assign do_new    = (is_add || is_update) && !have_match_q && have_free_q;
	assign sel_idx   = (have_match_q && !is_add) ? match_idx_q : free_idx_q;
	assign slot_low  = 4'(sel_idx);

	// Entry written: a new entry starts connected and active, an update takes
	// every input field.
	always_comb begin
		wr_ent         = '0;
		wr_ent.addr    = req_q.key_ip;
		wr_ent.portnum = req_q.key_port;
		wr_ent.ident   = req_q.peer_id;
		wr_ent.flags.server = req_q.server_in;
		if (do_upd) begin
			wr_ent.flags.connected = req_q.connected_in;
			wr_ent.flags.active    = req_q.active_in;
			wr_ent.stamp           = req_q.stamp_in;
		end else begin
			wr_ent.flags.connected = 1'b1;
			wr_ent.flags.active    = 1'b1;
			wr_ent.stamp           = is_update ? 32'd0 : free_stamp_q;
		end
	end

	assign wr.en   = (state_q == ST_WRITE) && (do_new || do_upd);
	assign wr.data = wr_ent;
	assign wr_addr = sel_idx;

	// Inactive slots left after the write, other than an updated match.
	assign inact_left = inact_q - CNT_W'(do_new)
		- CNT_W'(do_upd && !match_ent_q.flags.active);

	// Result of the request.
	always_comb begin
		res_d            = '0;
		res_d.status     = pct_pkg::ST_NONE;
		res_d.table_full = (inact_left == '0) && !(do_upd && !req_q.active_in);
		if (do_new || do_upd) begin
			res_d.status        = do_upd ? pct_pkg::ST_FOUND : pct_pkg::ST_NEW;
			res_d.slot          = slot_low;
			res_d.out_id        = wr_ent.ident;
			res_d.out_connected = wr_ent.flags.connected;
			res_d.out_server    = wr_ent.flags.server;
			res_d.out_active    = wr_ent.flags.active;
			res_d.out_stamp     = wr_ent.stamp;
		end else if (is_add && have_match_q) begin
			res_d.status = pct_pkg::ST_PRESENT;
		end else if (!is_add && !is_update && have_match_q) begin
			res_d.status        = pct_pkg::ST_FOUND;
			res_d.slot          = slot_low;
			res_d.out_id        = match_ent_q.ident;
			res_d.out_connected = match_ent_q.flags.connected;
			res_d.out_server    = match_ent_q.flags.server;
			res_d.out_active    = match_ent_q.flags.active;
			res_d.out_stamp     = match_ent_q.stamp;
		end
	end

	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Sequencer and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_q      <= '0;
			n_q          <= '0;
			rvld_s1      <= 1'b0;
			last_s1      <= 1'b0;
			have_match_q <= 1'b0;
			have_free_q  <= 1'b0;
			inact_q      <= '0;
		end else begin
			rvld_s1 <= rd_en;
			if (rd_en) begin
				issue_q <= issue_nxt;
				last_s1 <= (issue_nxt == n_q);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						issue_q      <= '0;
						n_q          <= n_used;
						have_match_q <= 1'b0;
						have_free_q  <= 1'b0;
						inact_q      <= '0;
						state_q      <= (n_used == '0) ? ST_WRITE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rvld_s1) begin
						if (key_hit && !have_match_q) begin
							have_match_q <= 1'b1;
						end
						if (!rd_data.flags.active) begin
							inact_q <= inact_q + 1'b1;
							if (!have_free_q) begin
								have_free_q <= 1'b1;
							end
						end
						if (last_s1) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload captured at request transfer, during the scan, at write-back and at result hand-off.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_q.req_type     <= req.req_type;
			req_q.key_ip       <= req.key_ip;
			req_q.key_port     <= req.key_port;
			req_q.peer_id      <= req.peer_id;
			req_q.connected_in <= req.connected_in;
			req_q.server_in    <= req.server_in;
			req_q.active_in    <= req.active_in;
			req_q.stamp_in     <= req.stamp_in;
		end
		ridx_s1 <= rd_addr;
		if ((state_q == ST_SCAN) && rvld_s1) begin
			if (key_hit && !have_match_q) begin
				match_idx_q <= ridx_s1;
				match_ent_q <= rd_data;
			end
			if (!rd_data.flags.active && !have_free_q) begin
				free_idx_q   <= ridx_s1;
				free_stamp_q <= rd_data.stamp;
			end
		end
		if (state_q == ST_WRITE) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.slot          = rsp_q.slot;
	assign rsp.out_id        = rsp_q.out_id;
	assign rsp.out_connected = rsp_q.out_connected;
	assign rsp.out_server    = rsp_q.out_server;
	assign rsp.out_active    = rsp_q.out_active;
	assign rsp.out_stamp     = rsp_q.out_stamp;
	assign rsp.table_full    = rsp_q.table_full;

`ifndef SYNTH
	// A write needs a found or a free slot and happens only at write-back.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_WRITE) && (have_match_q || have_free_q))
		else $error("table write outside write-back or without a slot");

	// The read pointer never runs past the slot count.
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= n_q))
		else $error("scan pointer beyond used slots");

	// Write-back is followed by the result hand-off state in the next cycle.
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |=> (state_q == ST_DONE))
		else $error("write-back not followed by result hand-off");

	// No read is pending once the scan has ended.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> !rvld_s1 && !rd_en)
		else $error("read in flight at write-back");
`endif

endmodule

FILE: rtl/peer_connection_table_core.sv
// ----------------------------------------------------------------------------
// peer_connection_table_core: associative peer table keyed by address and port
// Operation: a request is taken only in the idle state; the scan reads the n used
// slots (n is the slot count, at most MAX_SLOTS) one slot a cycle through the single
// key comparator and read port, then comes the write-back, then the result is
// registered; the scan is skipped when no slot is in use. A new request is taken
// only once the result of the last one has been loaded into the output register.
// Reset: asynchronous; all slots read as cleared entries, slot count 16.
// ----------------------------------------------------------------------------
module peer_connection_table_core #(
	parameter int MAX_SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	pct_req_if.sink   req,
	pct_rsp_if.source rsp,
	pct_cfg_if.sink   cfg
);

	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	logic [4:0]          slots_q;
	logic [CMP_W-1:0]    slots_ext;
	logic [CMP_W-1:0]    max_ext;
	logic [CMP_W-1:0]    n_ext;
	logic [CNT_W-1:0]    n_used;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	pct_pkg::pct_entry_t rd_data;
	logic [IDX_W-1:0]    wr_addr;
	pct_pkg::pct_wr_t    wr;

	// Slot count register; always ready for a transfer.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= pct_pkg::SLOTS_RESET;
		end else if (cfg.valid) begin
			slots_q <= cfg.data;
		end
	end

	// Used slot count saturates at the table depth.
	assign slots_ext = CMP_W'(slots_q);
	assign max_ext   = CMP_W'(MAX_SLOTS);
	assign n_ext     = (slots_ext > max_ext) ? max_ext : slots_ext;
	assign n_used    = n_ext[CNT_W-1:0];

	pct_store #(
		.MAX_SLOTS (MAX_SLOTS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

	pct_ctrl #(
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.n_used  (n_used),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_addr (wr_addr),
		.wr      (wr)
	);

endmodule

FILE: tb/sv/tb_peer_connection_table_core.sv
// ----------------------------------------------------------------------------
// tb_peer_connection_table_core: self-checking bench for the peer table core
// Drives requests and slot count writes over the valid/ready channels, keeps
// its own copy of the table to work out every result, and compares each
// result transfer field by field. Directed cases come first, then random
// phases over several slot counts, with random idling on both sides and one
// long result stall.
// ----------------------------------------------------------------------------
module tb_peer_connection_table_core;

	localparam int TBL_DEPTH   = 16;
	localparam int RUN_LIMIT   = 2000000;
	localparam int SETTLE_CYC  = 24;
	localparam int POOL_SIZE   = 20;
	localparam int HOLD_CYC    = 200;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic rsp_hold = 1'b0;

	int req_idle_pct = 15;
	int rsp_idle_pct = 15;
	int fail_count = 0;

	// Mirror of the table and of the slot count register.
	pct_pkg::pct_entry_t tbl_mirror [TBL_DEPTH];
	logic [4:0]          slot_count;
	pct_pkg::pct_rsp_t   pending_rsp [$];

	// Keys that the random part draws from, so that matches are common.
	logic [31:0] pool_ip [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];

	pct_req_if req_ch ();
	pct_rsp_if rsp_ch ();
	pct_cfg_if cfg_ch ();

	peer_connection_table_core #(
		.MAX_SLOTS(TBL_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// Work out the result of one request and apply it to the mirror.
	function automatic pct_pkg::pct_rsp_t table_lookup_result(input pct_pkg::pct_req_t r);
		int n;
		int hit;
		int vacant;
		int s;
		bit found;
		bit has_vacant;
		bit full;
		pct_pkg::pct_rsp_t res;
		n = (slot_count > TBL_DEPTH) ? TBL_DEPTH : int'(slot_count);
		found = 1'b0;
		has_vacant = 1'b0;
		hit = 0;
		vacant = 0;
		s = 0;
		// The scan stops at the first key match; a free slot before it counts.
		for (int i = 0; i < n && !found; i++) begin
			if (!has_vacant && !tbl_mirror[i].flags.active) begin
				has_vacant = 1'b1;
				vacant = i;
			end
			if (tbl_mirror[i].addr == r.key_ip && tbl_mirror[i].portnum == r.key_port) begin
				found = 1'b1;
				hit = i;
			end
		end
		res = '0;
		res.status = pct_pkg::ST_NONE;
		case (r.req_type)
			pct_pkg::REQ_ADD: begin
				if (found) begin
					res.status = pct_pkg::ST_PRESENT;
				end else if (has_vacant) begin
					s = vacant;
					tbl_mirror[s].addr = r.key_ip;
					tbl_mirror[s].portnum = r.key_port;
					tbl_mirror[s].ident = r.peer_id;
					tbl_mirror[s].flags.connected = 1'b1;
					tbl_mirror[s].flags.server = r.server_in;
					tbl_mirror[s].flags.active = 1'b1;
					res.status = pct_pkg::ST_NEW;
				end
			end
			pct_pkg::REQ_UPDATE: begin
				if (found) begin
					s = hit;
					tbl_mirror[s].ident = r.peer_id;
					tbl_mirror[s].flags.connected = r.connected_in;
					tbl_mirror[s].flags.server = r.server_in;
					tbl_mirror[s].flags.active = r.active_in;
					tbl_mirror[s].stamp = r.stamp_in;
					res.status = pct_pkg::ST_FOUND;
				end else if (has_vacant) begin
					s = vacant;
					tbl_mirror[s].addr = r.key_ip;
					tbl_mirror[s].portnum = r.key_port;
					tbl_mirror[s].ident = r.peer_id;
					tbl_mirror[s].flags.connected = 1'b1;
					tbl_mirror[s].flags.server = r.server_in;
					tbl_mirror[s].flags.active = 1'b1;
					tbl_mirror[s].stamp = '0;
					res.status = pct_pkg::ST_NEW;
				end
			end
			default: begin
				if (found) begin
					s = hit;
					res.status = pct_pkg::ST_FOUND;
				end
			end
		endcase
		if (res.status == pct_pkg::ST_NEW || res.status == pct_pkg::ST_FOUND) begin
			res.slot = s[3:0];
			res.out_id = tbl_mirror[s].ident;
			res.out_connected = tbl_mirror[s].flags.connected;
			res.out_server = tbl_mirror[s].flags.server;
			res.out_active = tbl_mirror[s].flags.active;
			res.out_stamp = tbl_mirror[s].stamp;
		end
		full = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (!tbl_mirror[i].flags.active)
				full = 1'b0;
		end
		res.table_full = full;
		return res;
	endfunction

	function automatic pct_pkg::pct_req_t mk_req(input logic [1:0] kind,
		input logic [31:0] ip, input logic [15:0] port, input logic [7:0] id,
		input logic conn, input logic serv, input logic act, input logic [31:0] stamp);
		pct_pkg::pct_req_t r;
		r.req_type = kind;
		r.key_ip = ip;
		r.key_port = port;
		r.peer_id = id;
		r.connected_in = conn;
		r.server_in = serv;
		r.active_in = act;
		r.stamp_in = stamp;
		return r;
	endfunction

	// Random request: mostly pooled keys, now and then a fresh key.
	function automatic pct_pkg::pct_req_t rand_req();
		int p;
		int k;
		logic [1:0] kind;
		logic [31:0] ip;
		logic [15:0] port;
		p = $urandom_range(99);
		if (p < 35)
			kind = pct_pkg::REQ_ADD;
		else if (p < 70)
			kind = pct_pkg::REQ_UPDATE;
		else if (p < 95)
			kind = pct_pkg::REQ_LOOKUP;
		else
			kind = REQ_SPARE;
		if ($urandom_range(99) < 85) begin
			k = $urandom_range(POOL_SIZE - 1);
			ip = pool_ip[k];
			port = pool_port[k];
		end else begin
			ip = $urandom;
			port = 16'($urandom_range(16'hFFFF));
		end
		return mk_req(kind, ip, port, 8'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)), ($urandom_range(99) < 70), $urandom);
	endfunction

	// Offer one request and record its expected result once it transfers.
	task automatic send_req(input pct_pkg::pct_req_t r);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.req_type;
		req_ch.key_ip <= r.key_ip;
		req_ch.key_port <= r.key_port;
		req_ch.peer_id <= r.peer_id;
		req_ch.connected_in <= r.connected_in;
		req_ch.server_in <= r.server_in;
		req_ch.active_in <= r.active_in;
		req_ch.stamp_in <= r.stamp_in;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_rsp.push_back(table_lookup_result(r));
	endtask

	// Stop offering requests and wait until every expected result has come.
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_slot_count(input logic [4:0] value);
		drain_requests();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		slot_count = value;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Result side: random ready, held low while a stall is under way.
	always @(posedge clk) begin
		rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		pct_pkg::pct_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual status %0d",
					$time, rsp_ch.status);
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_ch.status));
				check_field("slot", 32'(want.slot), 32'(rsp_ch.slot));
				check_field("out_id", 32'(want.out_id), 32'(rsp_ch.out_id));
				check_field("out_connected", 32'(want.out_connected),
					32'(rsp_ch.out_connected));
				check_field("out_server", 32'(want.out_server), 32'(rsp_ch.out_server));
				check_field("out_active", 32'(want.out_active), 32'(rsp_ch.out_active));
				check_field("out_stamp", want.out_stamp, rsp_ch.out_stamp);
				check_field("table_full", 32'(want.table_full), 32'(rsp_ch.table_full));
			end
		end
	end

	// Fresh table: the cleared key, add, add-or-update, lookups and reuse of a freed slot.
	task automatic test_fresh_table();
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'h0, 16'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0,
			1'b0, 32'h0));
		send_req(mk_req(pct_pkg::REQ_ADD, 32'hC0A8_0001, 16'h1F90, 8'hFF, 1'b0, 1'b1, 1'b0,
			32'hFFFF_FFFF));
		send_req(mk_req(pct_pkg::REQ_ADD, 32'hC0A8_0001, 16'h1F90, 8'h11, 1'b1, 1'b0, 1'b1,
			32'h0));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'hC0A8_0001, 16'h1F90, 8'hFF, 1'b1, 1'b1,
			1'b1, 32'hFFFF_FFFF));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0,
			1'b0, 32'hDEAD_BEEF));
		send_req(mk_req(REQ_SPARE, 32'hC0A8_0001, 16'h1F90, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
		// The cleared key still sits in the first inactive slot and matches.
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0, 16'h0, 8'h5A, 1'b1, 1'b1, 1'b1, 32'h0));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'hC0A8_0001, 16'h1F90, 8'h00, 1'b0, 1'b0,
			1'b0, 32'h1234_5678));
		// An add into the freed slot keeps its old stamp.
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0A00_0002, 16'h0050, 8'h42, 1'b0, 1'b0, 1'b0,
			32'h0));
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'hC0A8_0001, 16'h1F90, 8'h00, 1'b0, 1'b0,
			1'b0, 32'h0));
	endtask

	// Small, zero and oversized slot counts.
	task automatic test_slot_limits();
		write_slot_count(5'd1);
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'h0A00_0002, 16'h0050, 8'h00, 1'b0, 1'b0,
			1'b0, 32'h0));
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0A00_0003, 16'h0051, 8'h01, 1'b0, 1'b0, 1'b0,
			32'h0));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'h0A00_0003, 16'h0051, 8'h01, 1'b1, 1'b1,
			1'b1, 32'h7));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'h0A00_0002, 16'h0050, 8'h02, 1'b1, 1'b0,
			1'b0, 32'h9));
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0A00_0003, 16'h0051, 8'h03, 1'b0, 1'b1, 1'b0,
			32'h0));
		write_slot_count(5'd0);
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0A00_0004, 16'h0052, 8'h04, 1'b0, 1'b0, 1'b0,
			32'h0));
		send_req(mk_req(pct_pkg::REQ_UPDATE, 32'h0A00_0004, 16'h0052, 8'h04, 1'b1, 1'b1,
			1'b1, 32'h1));
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'h0, 16'h0, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0));
		write_slot_count(5'd31);
		send_req(mk_req(pct_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1'b0, 1'b0,
			1'b0, 32'h0));
		send_req(mk_req(pct_pkg::REQ_ADD, 32'h0A00_0005, 16'h0053, 8'h05, 1'b0, 1'b1, 1'b0,
			32'h0));
		write_slot_count(pct_pkg::SLOTS_RESET);
	endtask

	// Results are held off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		req_idle_pct = 0;
		fork
			begin
				rsp_hold <= 1'b1;
				repeat (HOLD_CYC) @(posedge clk);
				rsp_hold <= 1'b0;
			end
		join_none
		for (int i = 0; i < 10; i++)
			send_req(rand_req());
		req_idle_pct = 15;
	endtask

	// Random phases over several slot counts, one of them with no idling.
	task automatic test_random_traffic();
		logic [4:0] phase_slots [7];
		int phase_items [7];
		pool_ip[0] = 32'h0;
		pool_port[0] = 16'h0;
		pool_ip[1] = 32'hFFFF_FFFF;
		pool_port[1] = 16'hFFFF;
		for (int k = 2; k < POOL_SIZE; k++) begin
			pool_ip[k] = $urandom;
			pool_port[k] = 16'($urandom_range(16'hFFFF));
		end
		phase_slots = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd16, 5'd0, 5'd16};
		phase_slots[6] = 5'($urandom_range(2, 15));
		phase_items = '{110, 100, 100, 60, 130, 20, 100};
		for (int p = 0; p < 7; p++) begin
			write_slot_count(phase_slots[p]);
			if (p == 4) begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end else begin
				req_idle_pct = 15;
				rsp_idle_pct = 15;
			end
			for (int i = 0; i < phase_items[p]; i++)
				send_req(rand_req());
		end
		req_idle_pct = 15;
		rsp_idle_pct = 15;
	endtask

	// Overall time limit.
	initial begin
		#(RUN_LIMIT);
		$display("[peer_connection_table_core] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = pct_pkg::REQ_ADD;
		req_ch.key_ip = '0;
		req_ch.key_port = '0;
		req_ch.peer_id = '0;
		req_ch.connected_in = 1'b0;
		req_ch.server_in = 1'b0;
		req_ch.active_in = 1'b0;
		req_ch.stamp_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		for (int i = 0; i < TBL_DEPTH; i++)
			tbl_mirror[i] = '0;
		slot_count = pct_pkg::SLOTS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fresh_table();
		test_slot_limits();
		test_backpressure();
		test_random_traffic();

		drain_requests();
		repeat (SETTLE_CYC) @(posedge clk);
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("[peer_connection_table_core] OK");
		end else begin
			$display("[peer_connection_table_core] ERROR");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/pct_pkg.sv
rtl/pct_if.sv
rtl/pct_store.sv
rtl/pct_ctrl.sv
rtl/peer_connection_table_core.sv
tb/sv/tb_peer_connection_table_core.sv
